@@ hw/rtl/tch_pkg.sv @@
// Shared constants and arctangent table for the tilt-compensated heading pipeline.
package tch_pkg;
    localparam int GUARD_BITS = 8;
    localparam int GAIN_FRAC  = 28;
    localparam int ZW         = 34;
    localparam logic signed [28:0] INV_GAIN = 29'sd163008219;
    localparam logic signed [ZW-1:0] HALF_TURN    = 34'sd2147483648;
    localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;

    // floor(atan(2^-i) * 2^31 / pi)
    function automatic logic [31:0] atan_val(input int idx);
        logic [31:0] v;
        begin
            unique case (idx)
                0: v = 32'd536870912;
                1: v = 32'd316933405;
                2: v = 32'd167458907;
                3: v = 32'd85004756;
                4: v = 32'd42667331;
                5: v = 32'd21354465;
                6: v = 32'd10679838;
                7: v = 32'd5340245;
                8: v = 32'd2670163;
                9: v = 32'd1335086;
                10: v = 32'd667544;
                11: v = 32'd333772;
                12: v = 32'd166886;
                13: v = 32'd83443;
                14: v = 32'd41721;
                15: v = 32'd20860;
                16: v = 32'd10430;
                17: v = 32'd5215;
                18: v = 32'd2607;
                19: v = 32'd1303;
                20: v = 32'd651;
                21: v = 32'd325;
                22: v = 32'd162;
                23: v = 32'd81;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction
endpackage

@@ hw/rtl/tch_cordic_cell.sv @@
// One registered CORDIC micro-rotation cell, rotation or vectoring mode.
module tch_cordic_cell #(
    parameter int W   = 28,
    parameter int SW  = 1,
    parameter int IDX = 0,
    parameter int VEC = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [W-1:0]          i_x,
    input  logic signed [W-1:0]          i_y,
    input  logic signed [tch_pkg::ZW-1:0] i_z,
    input  logic [SW-1:0]                i_side,
    output logic                         o_valid,
    output logic signed [W-1:0]          o_x,
    output logic signed [W-1:0]          o_y,
    output logic signed [tch_pkg::ZW-1:0] o_z,
    output logic [SW-1:0]                o_side
);
    logic signed [W-1:0]           xs, ys, n_x, n_y;
    logic signed [tch_pkg::ZW-1:0] at, n_z;
    logic                          pos;
    logic                          r_valid;
    logic signed [W-1:0]           r_x, r_y;
    logic signed [tch_pkg::ZW-1:0] r_z;
    logic [SW-1:0]                 r_side;

    always_comb begin
        xs  = i_x >>> IDX;
        ys  = i_y >>> IDX;
        at  = tch_pkg::ZW'({1'b0, tch_pkg::atan_val(IDX)});
        // vectoring steers on sign of y, rotation on sign of remaining angle
        pos = (VEC != 0) ? i_y[W-1] : !i_z[tch_pkg::ZW-1];
        if (pos) begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - at;
        end else begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;
endmodule

@@ hw/rtl/tilt_compensated_heading_top.sv @@
// Top level: tilt-compensated compass heading, three pipelined CORDIC cell chains.
//
// Channel   Dir  Handshake              Payload
// s_axis    in   i_s_tvalid/o_s_tready  i_s_tdata: mag_x, mag_y, mag_z, roll, pitch
// m_axis    out  o_m_tvalid/i_m_tready  o_m_tdata: heading
//
// One request accepted per cycle while the output is not stalled; the path runs
// through input register, roll chain, gain multiply, pitch chain, vectoring chain, rounding.
// Throughput is set by the single pipeline enable: all stages advance together.
// Reset (synchronous, active low) clears only the valid bits.
// When the output holds a result that is not taken, the whole pipeline stalls
// and o_s_tready drops in the same cycle; bubbles move forward otherwise.
module tilt_compensated_heading_top #(
    parameter int SAMPLE_BITS   = 16,
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // mag_x, mag_y, mag_z (SAMPLE_BITS each), roll, pitch (ANGLE_BITS each), zero pad
    input  logic [((3*SAMPLE_BITS+2*ANGLE_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // heading (ANGLE_BITS), zero pad
    output logic [((ANGLE_BITS+7)/8)*8-1:0] o_m_tdata
);
    localparam int SB  = SAMPLE_BITS;
    localparam int AB  = ANGLE_BITS;
    localparam int S   = CORDIC_STAGES;
    localparam int W   = SAMPLE_BITS + 12;     // guard bits plus gain growth headroom
    localparam int ZW  = tch_pkg::ZW;
    localparam int PW  = W + 29;               // product width
    localparam int OW  = ((ANGLE_BITS+7)/8)*8;
    localparam int ASH = 32 - ANGLE_BITS;

    logic en;
    assign en         = !(o_m_tvalid && !i_m_tready);
    assign o_s_tready = en;

    // ---- input unpack and roll quadrant pre-step
    logic signed [W-1:0]  mx, my, mz, n_ax, n_ay;
    logic signed [ZW-1:0] zr, zp, n_az;
    always_comb begin
        mx = {{(W-SB){i_s_tdata[SB-1]}}, i_s_tdata[SB-1:0]} <<< tch_pkg::GUARD_BITS;
        my = {{(W-SB){i_s_tdata[2*SB-1]}}, i_s_tdata[2*SB-1:SB]} <<< tch_pkg::GUARD_BITS;
        mz = {{(W-SB){i_s_tdata[3*SB-1]}}, i_s_tdata[3*SB-1:2*SB]} <<< tch_pkg::GUARD_BITS;
        zr = {{(ZW-AB){i_s_tdata[3*SB+AB-1]}}, i_s_tdata[3*SB+AB-1:3*SB]} <<< ASH;
        zp = {{(ZW-AB){i_s_tdata[3*SB+2*AB-1]}}, i_s_tdata[3*SB+2*AB-1:3*SB+AB]} <<< ASH;
        n_ax = my;
        n_ay = mz;
        n_az = zr;
        if (zr > tch_pkg::QUARTER_TURN) begin
            n_ax = -my; n_ay = -mz; n_az = zr - tch_pkg::HALF_TURN;
        end else if (zr < -tch_pkg::QUARTER_TURN) begin
            n_ax = -my; n_ay = -mz; n_az = zr + tch_pkg::HALF_TURN;
        end
    end

    logic                 rv [0:S];
    logic signed [W-1:0]  rx [0:S];
    logic signed [W-1:0]  ry [0:S];
    logic signed [ZW-1:0] rz [0:S];
    logic [W+ZW-1:0]      rs [0:S];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rv[0] <= 1'b0;
        end else if (en) begin
            rv[0] <= i_s_tvalid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            rx[0] <= n_ax;
            ry[0] <= n_ay;
            rz[0] <= n_az;
            rs[0] <= {mx, zp};
        end
    end

    // ---- roll chain: (my, mz) -> (K*mw_y, K*t), side carries mx and pitch angle
    genvar gi;
    generate
        for (gi = 0; gi < S; gi++) begin : g_roll
            tch_cordic_cell #(.W(W), .SW(W+ZW), .IDX(gi), .VEC(0)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
                .i_valid(rv[gi]), .i_x(rx[gi]), .i_y(ry[gi]), .i_z(rz[gi]),
                .i_side(rs[gi]),
                .o_valid(rv[gi+1]), .o_x(rx[gi+1]), .o_y(ry[gi+1]), .o_z(rz[gi+1]),
                .o_side(rs[gi+1])
            );
        end
    endgenerate

    // ---- gain correction multiply on t
    logic                 r_gv;
    logic signed [PW-1:0] r_prod;
    logic signed [W-1:0]  r_ga, r_gmx;
    logic signed [ZW-1:0] r_gzp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv <= 1'b0;
        end else if (en) begin
            r_gv <= rv[S];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= PW'(ry[S]) * PW'(tch_pkg::INV_GAIN);
            r_ga   <= rx[S];
            r_gmx  <= rs[S][W+ZW-1:ZW];
            r_gzp  <= rs[S][ZW-1:0];
        end
    end

    // ---- rounding of t and pitch quadrant pre-step
    logic signed [PW-1:0] tsum;
    logic signed [W-1:0]  tt, n_px, n_py;
    logic signed [ZW-1:0] n_pz;
    always_comb begin
        tsum = (r_prod + (PW'(1) <<< (tch_pkg::GAIN_FRAC-1))) >>> tch_pkg::GAIN_FRAC;
        tt   = tsum[W-1:0];
        n_px = tt;
        n_py = r_gmx;
        n_pz = r_gzp;
        if (r_gzp > tch_pkg::QUARTER_TURN) begin
            n_px = -tt; n_py = -r_gmx; n_pz = r_gzp - tch_pkg::HALF_TURN;
        end else if (r_gzp < -tch_pkg::QUARTER_TURN) begin
            n_px = -tt; n_py = -r_gmx; n_pz = r_gzp + tch_pkg::HALF_TURN;
        end
    end

    logic                 pv [0:S];
    logic signed [W-1:0]  px [0:S];
    logic signed [W-1:0]  py [0:S];
    logic signed [ZW-1:0] pz [0:S];
    logic [W-1:0]         ps [0:S];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            pv[0] <= 1'b0;
        end else if (en) begin
            pv[0] <= r_gv;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            px[0] <= n_px;
            py[0] <= n_py;
            pz[0] <= n_pz;
            ps[0] <= r_ga;
        end
    end

    // ---- pitch chain: (t, mx) -> y becomes K*mw_x, side carries K*mw_y
    generate
        for (gi = 0; gi < S; gi++) begin : g_pitch
            tch_cordic_cell #(.W(W), .SW(W), .IDX(gi), .VEC(0)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
                .i_valid(pv[gi]), .i_x(px[gi]), .i_y(py[gi]), .i_z(pz[gi]),
                .i_side(ps[gi]),
                .o_valid(pv[gi+1]), .o_x(px[gi+1]), .o_y(py[gi+1]), .o_z(pz[gi+1]),
                .o_side(ps[gi+1])
            );
        end
    endgenerate

    // ---- vectoring setup: X = mw_x, Y = -mw_y, left half-plane folded by pi
    logic signed [W-1:0]  vx0, vy0, n_vx, n_vy;
    logic signed [ZW-1:0] n_vz;
    logic                 n_zero;
    always_comb begin
        vx0    = py[S];
        vy0    = -$signed(ps[S]);
        n_zero = (vx0 == '0) && (vy0 == '0);
        n_vx   = vx0;
        n_vy   = vy0;
        n_vz   = '0;
        if (vx0[W-1]) begin
            n_vx = -vx0; n_vy = -vy0; n_vz = tch_pkg::HALF_TURN;
        end
    end

    logic                 vv [0:S];
    logic signed [W-1:0]  vx [0:S];
    logic signed [W-1:0]  vy [0:S];
    logic signed [ZW-1:0] vz [0:S];
    logic [0:0]           vs [0:S];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            vv[0] <= 1'b0;
        end else if (en) begin
            vv[0] <= pv[S];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            vx[0] <= n_vx;
            vy[0] <= n_vy;
            vz[0] <= n_vz;
            vs[0] <= n_zero;
        end
    end

    // ---- vectoring chain, side carries the both-zero flag
    generate
        for (gi = 0; gi < S; gi++) begin : g_vec
            tch_cordic_cell #(.W(W), .SW(1), .IDX(gi), .VEC(1)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
                .i_valid(vv[gi]), .i_x(vx[gi]), .i_y(vy[gi]), .i_z(vz[gi]),
                .i_side(vs[gi]),
                .o_valid(vv[gi+1]), .o_x(vx[gi+1]), .o_y(vy[gi+1]), .o_z(vz[gi+1]),
                .o_side(vs[gi+1])
            );
        end
    endgenerate

    // ---- output rounding to ANGLE_BITS, wraps so +pi reads as -pi
    logic signed [ZW-1:0] zround;
    logic [AB-1:0]        n_head;
    logic                 r_out_valid, r_out_zero;
    logic [AB-1:0]        r_head;
    always_comb begin
        zround = (vz[S] + (ZW'(1) <<< (31-AB))) >>> ASH;
        n_head = vs[S][0] ? '0 : zround[AB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= vv[S];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_head     <= n_head;
            r_out_zero <= vs[S][0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OW'(r_head);

    // ---- checks
    a_zero_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_zero) |-> (r_head == '0))
        else $error("zero level vector gave nonzero heading");
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(rv[0]) && $stable(pv[0]) && $stable(vv[0])))
        else $error("pipeline moved during stall");
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == !(o_m_tvalid && !i_m_tready))
        else $error("ready does not follow output stall");
endmodule
